/* rtl/mgsm_pkg.sv */
// shared types and constants for the multitrack gain sum mixer
// no dependencies; imported by every rtl module of the block

package mgsm_pkg;

    localparam int TRACKS = 16;

    localparam int SAMPLE_W  = 16;
    localparam int VOL_W     = 16;
    localparam int TGAIN_W   = 16;
    localparam int GAIN_W    = 18;
    localparam int ACC_W     = 32;
    localparam int PROD_W    = 34;
    localparam int SCALED_W  = PROD_W - 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 32;

    localparam logic [TGAIN_W-1:0] UNITY_Q13    = 16'd8192;
    localparam logic [TGAIN_W-1:0] GAIN_MAX_Q13 = 16'd32768;
    localparam logic [CFG_W-1:0]   GAINS_RESET  = 64'h2000_2000_2000_2000;
    localparam logic [15:0] LIVE_MASK =
        (TRACKS >= 16) ? 16'hFFFF : 16'((1 << TRACKS) - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAINS_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAINS_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOLO     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYING  = 3'd6;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic                       add_en;
        logic [GAIN_W-1:0]          gain;
        logic signed [SAMPLE_W-1:0] sl;
        logic signed [SAMPLE_W-1:0] sr;
        logic                       last;
        logic                       playing;
    } mgsm_item_t;

    typedef struct packed {
        logic                     add_en;
        logic                     last;
        logic                     playing;
        logic signed [PROD_W-1:0] prod_l;
        logic signed [PROD_W-1:0] prod_r;
    } mgsm_scaled_t;

endpackage

/* rtl/mgsm_front.sv */
// front end: configuration registers, input transfer and combined gain
// depends on mgsm_pkg

module mgsm_front
    import mgsm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  s_tuser,
    input  logic                  q_full,
    output logic                  q_push,
    output mgsm_item_t            q_item
);

    logic [CFG_W-1:0] gains_reg [4];
    logic [15:0]      mute_reg;
    logic [15:0]      solo_reg;
    logic             playing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                gains_reg[i] <= GAINS_RESET;
            end
            mute_reg    <= '0;
            solo_reg    <= '0;
            playing_reg <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_index <= REG_GAINS_3) begin
                gains_reg[cfg_index[1:0] - REG_GAINS_0[1:0]] <= cfg_wdata;
            end else if (cfg_index == REG_MUTE) begin
                mute_reg <= cfg_wdata[15:0];
            end else if (cfg_index == REG_SOLO) begin
                solo_reg <= cfg_wdata[15:0];
            end else if (cfg_index == REG_PLAYING) begin
                playing_reg <= cfg_wdata[0];
            end
        end
    end

    logic [3:0]         trk;
    logic [VOL_W-1:0]   vol;
    logic               cmute;
    logic [TGAIN_W-1:0] tg_raw;
    logic [TGAIN_W-1:0] tg;
    logic               audible;
    logic [31:0]        gprod;
    logic [GAIN_W-1:0]  gain;

    assign trk   = s_tdata[3:0];
    assign vol   = s_tdata[19:4];
    assign cmute = s_tdata[20];

    always_comb begin
        tg_raw = gains_reg[trk[3:2]][{trk[1:0], 4'b0000} +: TGAIN_W];
        if ((solo_reg & LIVE_MASK) != 16'd0) begin
            audible = solo_reg[trk];
        end else begin
            audible = !mute_reg[trk];
        end
        if (int'(trk) >= TRACKS) begin
            tg = UNITY_Q13;
        end else if (!audible) begin
            tg = '0;
        end else if (tg_raw > GAIN_MAX_Q13) begin
            tg = GAIN_MAX_Q13;
        end else begin
            tg = tg_raw;
        end
    end

    assign gprod = vol * tg;
    assign gain  = gprod[13 +: GAIN_W];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.add_en  = playing_reg && s_tuser && !cmute && (gain != '0);
        q_item.gain    = gain;
        q_item.sl      = s_tdata[36:21];
        q_item.sr      = s_tdata[52:37];
        q_item.last    = s_tlast;
        q_item.playing = playing_reg;
    end

endmodule

/* rtl/mgsm_queue.sv */
// short item queue that decouples the gain front from the mix back
// depends on mgsm_pkg

module mgsm_queue
    import mgsm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  mgsm_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       q_valid,
    output mgsm_item_t q_item
);

    mgsm_item_t     entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/mgsm_back.sv */
// back end: sample scaling, saturating accumulate and output register
// depends on mgsm_pkg

module mgsm_back
    import mgsm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  mgsm_item_t            q_item,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    function automatic logic signed [SCALED_W-1:0] trunc_q13(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] b;
        b = p + (p[PROD_W-1] ? PROD_W'(8191) : PROD_W'(0));
        return b[PROD_W-1:13];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]    a,
        input logic signed [SCALED_W-1:0] q);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W+1-SCALED_W){q[SCALED_W-1]}}, q};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp16(input logic signed [ACC_W-1:0] v);
        if (v > 32'sd32767) begin
            return 16'h7FFF;
        end else if (v < -32'sd32768) begin
            return 16'h8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    mgsm_scaled_t            s1_reg;
    logic                    s1_valid_reg;
    logic signed [ACC_W-1:0] acc_l_reg;
    logic signed [ACC_W-1:0] acc_r_reg;
    logic                    m_valid_reg;
    logic [OUT_DATA_W-1:0]   m_data_reg;

    logic                    acc_go;
    logic                    s1_load;
    logic signed [ACC_W-1:0] acc_l_next;
    logic signed [ACC_W-1:0] acc_r_next;
    logic signed [GAIN_W:0]  gain_s;

    assign acc_go  = s1_valid_reg && (!s1_reg.last || !m_valid_reg || m_tready);
    assign s1_load = !s1_valid_reg || acc_go;
    assign q_pop   = q_valid && s1_load;
    assign gain_s  = {1'b0, q_item.gain};

    always_comb begin
        if (s1_reg.add_en) begin
            acc_l_next = sat_add(acc_l_reg, trunc_q13(s1_reg.prod_l));
            acc_r_next = sat_add(acc_r_reg, trunc_q13(s1_reg.prod_r));
        end else begin
            acc_l_next = acc_l_reg;
            acc_r_next = acc_r_reg;
        end
    end

    // scale stage: one multiply per channel, registered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_load) begin
            s1_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_reg.add_en  <= q_item.add_en;
            s1_reg.last    <= q_item.last;
            s1_reg.playing <= q_item.playing;
            s1_reg.prod_l  <= PROD_W'(q_item.sl * gain_s);
            s1_reg.prod_r  <= PROD_W'(q_item.sr * gain_s);
        end
    end

    // accumulate stage and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_l_reg   <= '0;
            acc_r_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (acc_go) begin
                if (s1_reg.last) begin
                    acc_l_reg <= '0;
                    acc_r_reg <= '0;
                end else begin
                    acc_l_reg <= acc_l_next;
                    acc_r_reg <= acc_r_next;
                end
            end
            if (acc_go && s1_reg.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_go && s1_reg.last) begin
            if (s1_reg.playing) begin
                m_data_reg <= {clamp16(acc_r_next), clamp16(acc_l_next)};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* rtl/multitrack_gain_sum_mixer.sv */
// top level of the multitrack gain sum mixer
// depends on mgsm_pkg, mgsm_front, mgsm_queue and mgsm_back

// Stereo mixer for up to sixteen tracks. Each input transfer carries one clip
// sample with its track, clip volume and clip mute, or only closes a frame
// (s_tuser low). The front looks up the track gain (bounded to 4.0, zeroed by
// mute or by solo), multiplies it by the clip volume in Q3.13 and pushes the
// item into a four-entry queue. The back scales both samples with one
// multiplier per channel, truncates toward zero, and adds into saturating
// 32-bit accumulators. The transfer with s_tlast high emits one result with
// both sums clamped to 16 bits (zeros when not playing) and clears the sums.
// Throughput is one item per cycle while no frame result waits on m_tready.
// The front gain multiply settles in the accepting cycle and is written into
// the queue at that edge; the back scale multiply is registered in s1_reg and
// the accumulate in the sum and result registers, which raise m_tvalid.
// Configuration writes are taken at any time but must only be made while the
// block is idle.

module multitrack_gain_sum_mixer
    import mgsm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // track[3:0], clip_volume[19:4], clip_muted[20], sample_left[36:21],
    // sample_right[52:37], zero pad[55:53]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,   // last_of_frame
    input  logic                  s_tuser,   // has_sample
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // mix_left[15:0], mix_right[31:16]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // front to queue
    logic       q_push;
    logic       q_full;
    mgsm_item_t push_item;

    // queue to back
    logic       q_pop;
    logic       q_valid;
    mgsm_item_t q_item;

    mgsm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // decouples input transfers from a stalled result channel
    mgsm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    mgsm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
